// ----- rtl/c8eu_pkg.sv -----
// ----------------------------------------------------------------------------
// c8eu_pkg
// Shared operation codes, widths, reset values and interface structs of the
// CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8eu_pkg;

    localparam int FUNC_W  = 5;
    localparam int GPR_AW  = 4;
    localparam int DATA_W  = 8;
    localparam int ADDR_W  = 12;
    localparam int DEPTH_W = 4;

    localparam int GPR_COUNT         = 16;
    localparam int STACK_DEPTH_DFLT  = 16;

    typedef logic [FUNC_W-1:0]  t_func;
    typedef logic [GPR_AW-1:0]  t_gpr_idx;
    typedef logic [DATA_W-1:0]  t_byte;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [DEPTH_W-1:0] t_depth;

    localparam t_func FN_RET     = 5'd0;
    localparam t_func FN_JUMP    = 5'd1;
    localparam t_func FN_CALL    = 5'd2;
    localparam t_func FN_SKEQ_I  = 5'd3;
    localparam t_func FN_SKNE_I  = 5'd4;
    localparam t_func FN_SKEQ_R  = 5'd5;
    localparam t_func FN_LOAD    = 5'd6;
    localparam t_func FN_ADDI    = 5'd7;
    localparam t_func FN_MOVE    = 5'd8;
    localparam t_func FN_OR      = 5'd9;
    localparam t_func FN_AND     = 5'd10;
    localparam t_func FN_XOR     = 5'd11;
    localparam t_func FN_ADDC    = 5'd12;
    localparam t_func FN_SUB     = 5'd13;
    localparam t_func FN_SHR     = 5'd14;
    localparam t_func FN_SHL     = 5'd15;
    localparam t_func FN_SKNE_R  = 5'd16;
    localparam t_func FN_LDI     = 5'd17;
    localparam t_func FN_JUMPV0  = 5'd18;

    localparam t_gpr_idx GPR_V0 = 4'h0;
    localparam t_gpr_idx GPR_VF = 4'hF;

    localparam t_addr PC_RESET  = 12'h200;
    localparam t_addr PC_SKIP   = 12'd2;

    // Register file write request, with the separate flag write to VF.
    typedef struct packed {
        logic     we;
        t_gpr_idx addr;
        t_byte    data;
        logic     flag_we;
        t_byte    flag;
    } t_gpr_wr;

    // Return stack command.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

endpackage

// ----- rtl/c8eu_gpr.sv -----
// ----------------------------------------------------------------------------
// c8eu_gpr
// General purpose register file V0..VF with operand read at item transfer.
// ----------------------------------------------------------------------------
module c8eu_gpr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  c8eu_pkg::t_gpr_idx i_rd_x,
    input  c8eu_pkg::t_gpr_idx i_rd_y,
    input  c8eu_pkg::t_gpr_idx i_ex_x,
    input  c8eu_pkg::t_gpr_idx i_ex_y,
    input  c8eu_pkg::t_gpr_wr  i_wr,
    output c8eu_pkg::t_byte    o_vx,
    output c8eu_pkg::t_byte    o_vy,
    output c8eu_pkg::t_byte    o_v0,
    output c8eu_pkg::t_byte    o_vf
);
    import c8eu_pkg::*;

    t_byte                 mem [GPR_COUNT];
    logic [GPR_COUNT-1:0]  r_valid;
    t_byte                 r_rd_x;
    t_byte                 r_rd_y;
    t_byte                 r_v0;
    t_byte                 r_vf;

    // Operands are read when the item enters the input register. A write from
    // the item retiring in the same cycle is forwarded. V0 and VF live in
    // their own flops, so later flag writes need no forwarding path.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            if (i_wr.we && i_wr.addr == i_rd_x) begin
                r_rd_x <= i_wr.data;
            end else begin
                r_rd_x <= r_valid[i_rd_x] ? mem[i_rd_x] : '0;
            end
            if (i_wr.we && i_wr.addr == i_rd_y) begin
                r_rd_y <= i_wr.data;
            end else begin
                r_rd_y <= r_valid[i_rd_y] ? mem[i_rd_y] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_v0    <= '0;
            r_vf    <= '0;
        end else begin
            if (i_wr.we) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_wr.we && i_wr.addr == GPR_V0) begin
                r_v0 <= i_wr.data;
            end
            if (i_wr.flag_we) begin
                r_vf <= i_wr.flag;
            end else if (i_wr.we && i_wr.addr == GPR_VF) begin
                r_vf <= i_wr.data;
            end
        end
    end

    assign o_vx = (i_ex_x == GPR_V0) ? r_v0 : ((i_ex_x == GPR_VF) ? r_vf : r_rd_x);
    assign o_vy = (i_ex_y == GPR_V0) ? r_v0 : ((i_ex_y == GPR_VF) ? r_vf : r_rd_y);
    assign o_v0 = r_v0;
    assign o_vf = r_vf;

endmodule

// ----- rtl/c8eu_stack.sv -----
// ----------------------------------------------------------------------------
// c8eu_stack
// Return address stack with wrapping pointer and a registered top entry.
// ----------------------------------------------------------------------------
module c8eu_stack #(
    parameter int STACK_DEPTH = c8eu_pkg::STACK_DEPTH_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c8eu_pkg::t_stk_cmd i_cmd,
    input  c8eu_pkg::t_addr    i_push_data,
    output c8eu_pkg::t_addr    o_top,
    output c8eu_pkg::t_depth   o_depth_next
);
    import c8eu_pkg::*;

    localparam int SpW = $clog2(STACK_DEPTH);

    t_addr          mem [STACK_DEPTH];
    logic [SpW-1:0] r_sp;
    logic [SpW-1:0] n_sp;
    t_addr          r_top;
    logic [SpW+3:0] sp_ext;

    always_comb begin
        n_sp = r_sp;
        if (i_cmd.push) begin
            n_sp = (r_sp == SpW'(STACK_DEPTH - 1)) ? '0 : r_sp + SpW'(1);
        end else if (i_cmd.pop) begin
            n_sp = (r_sp == '0) ? SpW'(STACK_DEPTH - 1) : r_sp - SpW'(1);
        end
    end

    // The top register always mirrors the entry under the pointer; a push
    // bypasses the memory so the new entry is visible at once.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[n_sp] <= i_push_data;
            r_top     <= i_push_data;
        end else begin
            r_top     <= mem[n_sp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else begin
            r_sp <= n_sp;
        end
    end

    assign sp_ext       = {4'b0000, n_sp};
    assign o_depth_next = sp_ext[DEPTH_W-1:0];
    assign o_top        = r_top;

endmodule

// ----- rtl/c8eu_alu.sv -----
// ----------------------------------------------------------------------------
// c8eu_alu
// Operation decoder and 8-bit ALU; computes the next architectural state.
// ----------------------------------------------------------------------------
module c8eu_alu (
    input  c8eu_pkg::t_func    i_func,
    input  c8eu_pkg::t_gpr_idx i_x,
    input  c8eu_pkg::t_byte    i_imm,
    input  c8eu_pkg::t_addr    i_addr,
    input  c8eu_pkg::t_byte    i_vx,
    input  c8eu_pkg::t_byte    i_vy,
    input  c8eu_pkg::t_byte    i_v0,
    input  c8eu_pkg::t_byte    i_vf,
    input  c8eu_pkg::t_addr    i_pc,
    input  c8eu_pkg::t_addr    i_index,
    input  c8eu_pkg::t_addr    i_stack_top,
    output c8eu_pkg::t_addr    o_pc,
    output c8eu_pkg::t_addr    o_index,
    output c8eu_pkg::t_gpr_wr  o_wr,
    output c8eu_pkg::t_stk_cmd o_stk,
    output c8eu_pkg::t_byte    o_vx,
    output c8eu_pkg::t_byte    o_vf
);
    import c8eu_pkg::*;

    logic [DATA_W:0] sum9;
    t_addr           pc_skip;

    assign sum9    = {1'b0, i_vx} + {1'b0, i_vy};
    assign pc_skip = i_pc + PC_SKIP;

    always_comb begin
        o_pc    = i_pc;
        o_index = i_index;
        o_wr    = '0;
        o_stk   = '0;
        o_wr.addr = i_x;
        unique case (i_func)
            FN_RET: begin
                o_pc      = i_stack_top;
                o_stk.pop = 1'b1;
            end
            FN_JUMP:   o_pc = i_addr;
            FN_CALL: begin
                o_pc       = i_addr;
                o_stk.push = 1'b1;
            end
            FN_SKEQ_I: o_pc = (i_vx == i_imm) ? pc_skip : i_pc;
            FN_SKNE_I: o_pc = (i_vx != i_imm) ? pc_skip : i_pc;
            FN_SKEQ_R: o_pc = (i_vx == i_vy)  ? pc_skip : i_pc;
            FN_SKNE_R: o_pc = (i_vx != i_vy)  ? pc_skip : i_pc;
            FN_LOAD: begin
                o_wr.we   = 1'b1;
                o_wr.data = i_imm;
            end
            FN_ADDI: begin
                o_wr.we   = 1'b1;
                o_wr.data = i_vx + i_imm;
            end
            FN_MOVE: begin
                o_wr.we   = 1'b1;
                o_wr.data = i_vy;
            end
            FN_OR: begin
                o_wr.we   = 1'b1;
                o_wr.data = i_vx | i_vy;
            end
            FN_AND: begin
                o_wr.we   = 1'b1;
                o_wr.data = i_vx & i_vy;
            end
            FN_XOR: begin
                o_wr.we   = 1'b1;
                o_wr.data = i_vx ^ i_vy;
            end
            FN_ADDC: begin
                o_wr.we      = 1'b1;
                o_wr.data    = sum9[DATA_W-1:0];
                o_wr.flag_we = 1'b1;
                o_wr.flag    = {7'b0000000, sum9[DATA_W]};
            end
            FN_SUB: begin
                o_wr.we      = 1'b1;
                o_wr.data    = i_vx - i_vy;
                o_wr.flag_we = 1'b1;
                o_wr.flag    = {7'b0000000, (i_vx >= i_vy)};
            end
            FN_SHR: begin
                o_wr.we      = 1'b1;
                o_wr.data    = {1'b0, i_vx[DATA_W-1:1]};
                o_wr.flag_we = 1'b1;
                o_wr.flag    = {7'b0000000, i_vx[0]};
            end
            FN_SHL: begin
                o_wr.we      = 1'b1;
                o_wr.data    = {i_vx[DATA_W-2:0], 1'b0};
                o_wr.flag_we = 1'b1;
                o_wr.flag    = {7'b0000000, i_vx[DATA_W-1]};
            end
            FN_LDI:    o_index = i_addr;
            FN_JUMPV0: o_pc = i_addr + {4'b0000, i_v0};
            default: begin
                // Unused codes leave all state as it is.
            end
        endcase
    end

    // The flag lands after the result, so it wins when x names VF.
    always_comb begin
        if (o_wr.flag_we && i_x == GPR_VF) begin
            o_vx = o_wr.flag;
        end else if (o_wr.we) begin
            o_vx = o_wr.data;
        end else begin
            o_vx = i_vx;
        end
        if (o_wr.flag_we) begin
            o_vf = o_wr.flag;
        end else if (o_wr.we && i_x == GPR_VF) begin
            o_vf = o_wr.data;
        end else begin
            o_vf = i_vf;
        end
    end

endmodule

// ----- rtl/chip8_execute_unit_core.sv -----
// ----------------------------------------------------------------------------
// chip8_execute_unit_core
// Executes one decoded CHIP-8 operation per transfer and reports the state.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | i_in_valid / o_in_ready   | func, reg_x, reg_y, imm_byte,
//          |           |                           | target_addr
//  out     | output    | o_out_valid / i_out_ready | pc_now, index_now, vx_now,
//          |           |                           | flag_now, depth_now
//
// One operation is accepted per clock cycle when the result side keeps up.
// The path is an input register, then one pass through the
// register file read, the 8-bit ALU and write-back into the result register.
// Reset is synchronous and active low; it clears the registers V0..VF through
// per-entry valid bits, sets the PC to 0x200 and needs no clearing pass.
// A stalled result holds the pipeline; the input register still takes an
// operation while the result register is full and the input register empty.
//
module chip8_execute_unit_core #(
    parameter int STACK_DEPTH = c8eu_pkg::STACK_DEPTH_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  c8eu_pkg::t_func    i_func,
    input  c8eu_pkg::t_gpr_idx i_reg_x,
    input  c8eu_pkg::t_gpr_idx i_reg_y,
    input  c8eu_pkg::t_byte    i_imm_byte,
    input  c8eu_pkg::t_addr    i_target_addr,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output c8eu_pkg::t_addr    o_pc_now,
    output c8eu_pkg::t_addr    o_index_now,
    output c8eu_pkg::t_byte    o_vx_now,
    output c8eu_pkg::t_byte    o_flag_now,
    output c8eu_pkg::t_depth   o_depth_now
);
    import c8eu_pkg::*;

    // Input register.
    logic     r_in_valid;
    t_func    r_func;
    t_gpr_idx r_reg_x;
    t_gpr_idx r_reg_y;
    t_byte    r_imm_byte;
    t_addr    r_target_addr;

    // Architectural PC and index register.
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] r_index;

    // Result register.
    logic   r_out_valid;
    t_addr  r_pc_now;
    t_addr  r_index_now;
    t_byte  r_vx_now;
    t_byte  r_flag_now;
    t_depth r_depth_now;

    logic     in_xfer;
    logic     ex_fire;

    t_byte    vx;
    t_byte    vy;
    t_byte    v0;
    t_byte    vf;
    t_addr    stack_top;
    t_depth   depth_next;

    t_addr    n_pc;
    t_addr    n_index;
    t_gpr_wr  alu_wr;
    t_gpr_wr  gpr_wr;
    t_stk_cmd alu_stk;
    t_stk_cmd stk_cmd;
    t_byte    n_vx;
    t_byte    n_vf;

    // The execute pass retires the held operation whenever the result
    // register is free or being drained in this cycle.
    assign ex_fire    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || ex_fire;
    assign in_xfer    = i_in_valid && o_in_ready;

    // State is only committed by the retiring operation.
    assign gpr_wr  = ex_fire ? alu_wr  : '0;
    assign stk_cmd = ex_fire ? alu_stk : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func        <= i_func;
            r_reg_x       <= i_reg_x;
            r_reg_y       <= i_reg_y;
            r_imm_byte    <= i_imm_byte;
            r_target_addr <= i_target_addr;
        end
    end

    // Operands are fetched as the operation enters the input register.
    c8eu_gpr u_gpr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (in_xfer),
        .i_rd_x  (i_reg_x),
        .i_rd_y  (i_reg_y),
        .i_ex_x  (r_reg_x),
        .i_ex_y  (r_reg_y),
        .i_wr    (gpr_wr),
        .o_vx    (vx),
        .o_vy    (vy),
        .o_v0    (v0),
        .o_vf    (vf)
    );

    c8eu_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (stk_cmd),
        .i_push_data  (r_pc),
        .o_top        (stack_top),
        .o_depth_next (depth_next)
    );

    c8eu_alu u_alu (
        .i_func      (r_func),
        .i_x         (r_reg_x),
        .i_imm       (r_imm_byte),
        .i_addr      (r_target_addr),
        .i_vx        (vx),
        .i_vy        (vy),
        .i_v0        (v0),
        .i_vf        (vf),
        .i_pc        (r_pc),
        .i_index     (r_index),
        .i_stack_top (stack_top),
        .o_pc        (n_pc),
        .o_index     (n_index),
        .o_wr        (alu_wr),
        .o_stk       (alu_stk),
        .o_vx        (n_vx),
        .o_vf        (n_vf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_RESET;
            r_index <= '0;
        end else if (ex_fire) begin
            r_pc    <= n_pc;
            r_index <= n_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ex_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_fire) begin
            r_pc_now    <= n_pc;
            r_index_now <= n_index;
            r_vx_now    <= n_vx;
            r_flag_now  <= n_vf;
            r_depth_now <= depth_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pc_now    = r_pc_now;
    assign o_index_now = r_index_now;
    assign o_vx_now    = r_vx_now;
    assign o_flag_now  = r_flag_now;
    assign o_depth_now = r_depth_now;

    // A retiring operation always produces a result in the next cycle.
    a_fire_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ex_fire |=> o_out_valid)
        else $error("retired operation produced no result");

    // A held operation is never dropped while the result side stalls.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !ex_fire) |=> r_in_valid)
        else $error("held operation lost");

    // Load index shows its address in the reported index register.
    a_ldi_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_fire && r_func == FN_LDI) |=> (o_index_now == $past(r_target_addr)))
        else $error("load index result mismatch");

    // Stack pointer only moves on call and return.
    a_depth_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ex_fire && r_out_valid && r_func != FN_CALL && r_func != FN_RET)
        |=> (o_depth_now == $past(o_depth_now)))
        else $error("stack pointer moved on a non-stack operation");

endmodule
